// ===== rtl/core/aole_pkg.sv =====
// Shared types and constants for the ordered array list engine.
package aole_pkg;

  // Fixed field widths of the command and result transactions
  localparam int POS_W  = 7;
  localparam int VAL_W  = 32;
  localparam int CNT_W  = 7;
  localparam int STAT_W = 2;

  // Command codes
  typedef enum logic [2:0] {
    CMD_INSERT    = 3'd0,
    CMD_DELETE    = 3'd1,
    CMD_READ      = 3'd2,
    CMD_OVERWRITE = 3'd3,
    CMD_SEARCH    = 3'd4,
    CMD_CLEAR     = 3'd5
  } cmd_t;

  // Result status codes
  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2
  } status_t;

  // Broadcast controls from the sequencer to every cell
  typedef struct packed {
    logic ins;   // shift up above position, write word at position
    logic del;   // shift down from position
    logic ovw;   // write word at position
    logic rd;    // drive entry at position onto the read bus
    logic srch;  // compare every live entry against the word
  } cell_ctrl_t;

endpackage

// ===== rtl/core/aole_if.sv =====
// Valid/ready channel interfaces for command and result transactions.
interface aole_in_if;
  logic                                valid;
  logic                                ready;
  logic [2:0]                          cmd;
  logic [aole_pkg::POS_W-1:0]          position;
  logic signed [aole_pkg::VAL_W-1:0]   value;

  modport source (output valid, output cmd, output position, output value, input ready);
  modport sink   (input valid, input cmd, input position, input value, output ready);
endinterface

interface aole_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [aole_pkg::VAL_W-1:0]   read_value;
  logic                                found;
  logic [aole_pkg::CNT_W-1:0]          count;
  logic [aole_pkg::STAT_W-1:0]         status;

  modport source (output valid, output read_value, output found, output count,
                  output status, input ready);
  modport sink   (input valid, input read_value, input found, input count,
                  input status, output ready);
endinterface

// ===== rtl/core/aole_cell.sv =====
// One list cell: holds a single entry and trades it with its neighbors.
module aole_cell #(
  parameter int DATA_WIDTH = 32,
  parameter int CNT_W      = 7,
  parameter int INDEX      = 0
) (
  input  logic                              clk,
  input  aole_pkg::cell_ctrl_t              ctrl_i,
  input  logic [aole_pkg::POS_W-1:0]        pos_i,
  input  logic [CNT_W-1:0]                  count_i,
  input  logic [DATA_WIDTH-1:0]             word_i,
  input  logic [DATA_WIDTH-1:0]             left_i,
  input  logic [DATA_WIDTH-1:0]             right_i,
  output logic [DATA_WIDTH-1:0]             data_o,
  output logic                              match_o,
  output logic [DATA_WIDTH-1:0]             rd_data_o
);

  localparam int CW = (CNT_W > aole_pkg::POS_W) ? CNT_W : aole_pkg::POS_W;

  logic [DATA_WIDTH-1:0] entry_r;
  logic [DATA_WIDTH-1:0] entry_nxt;
  logic [CW-1:0]         idx;
  logic [CW-1:0]         pos_x;
  logic                  at_pos;
  logic                  above;
  logic                  live;

  assign idx    = CW'(INDEX);
  assign pos_x  = CW'(pos_i);
  assign at_pos = (idx == pos_x);
  assign above  = (idx > pos_x);
  assign live   = (idx < CW'(count_i));

  // Next entry: shift from a neighbor or take the command word
  always_comb begin
    entry_nxt = entry_r;
    if (ctrl_i.ins && above) begin
      entry_nxt = left_i;
    end else if ((ctrl_i.ins || ctrl_i.ovw) && at_pos) begin
      entry_nxt = word_i;
    end else if (ctrl_i.del && (at_pos || above)) begin
      entry_nxt = right_i;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

  // Local compare and read select; the top ORs these over all cells
  assign data_o    = entry_r;
  assign match_o   = ctrl_i.srch && live && (entry_r == word_i);
  assign rd_data_o = (ctrl_i.rd && at_pos) ? entry_r : '0;

endmodule

// ===== rtl/core/ordered_array_list_engine.sv =====
// Top level of the ordered array list engine: command decode, cell row, result register.
// The list lives in a row of CAPACITY cells, one entry each; insert and delete move every
// entry above the position to its neighbor cell in the same clock, and search compares all
// live entries at once. Each command is accepted, the cells update and the result lands in the
// output register on the same edge, so results come out in the cycle after acceptance and a new
// command can be taken every cycle as long as the result side keeps up (the single output
// register sets that). Clear only zeroes the entry count; entry contents are undefined after
// reset and are never read until written. Position and count on the ports are 7 bits wide;
// value is a 32-bit signed word of which the low DATA_WIDTH bits are stored, and read_value
// is the stored entry sign-extended (or cut) to 32 bits.
module ordered_array_list_engine #(
  parameter int CAPACITY   = 64,
  parameter int DATA_WIDTH = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  aole_in_if.sink           in_ch,
  aole_out_if.source        out_ch
);

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int CW    = (CNT_W > aole_pkg::POS_W) ? CNT_W : aole_pkg::POS_W;

  logic                         accept;
  logic                         out_valid_r;
  logic [CNT_W-1:0]             count_r;
  logic [CNT_W-1:0]             count_nxt;
  logic [CW-1:0]                pos_x;
  logic [CW-1:0]                cnt_x;
  aole_pkg::status_t            status;
  aole_pkg::cell_ctrl_t         ctrl;
  aole_pkg::cell_ctrl_t         cell_ctrl;
  logic [DATA_WIDTH-1:0]        word;
  logic [DATA_WIDTH-1:0]        cell_data  [CAPACITY];
  logic [DATA_WIDTH-1:0]        cell_left  [CAPACITY];
  logic [DATA_WIDTH-1:0]        cell_right [CAPACITY];
  logic [DATA_WIDTH-1:0]        cell_rd    [CAPACITY];
  logic [CAPACITY-1:0]          cell_match;
  logic [DATA_WIDTH-1:0]        rd_any;
  logic signed [aole_pkg::VAL_W-1:0] rd_val_r;
  logic                         found_r;
  logic [aole_pkg::CNT_W-1:0]   count_out_r;
  logic [aole_pkg::STAT_W-1:0]  status_r;

  // Handshake: the output register frees as its transaction is taken
  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;

  // Stored word: input sign-extended or cut to the entry width
  assign word  = DATA_WIDTH'(in_ch.value);
  assign pos_x = CW'(in_ch.position);
  assign cnt_x = CW'(count_r);

  // Command decode and bounds checks
  always_comb begin
    ctrl      = '0;
    status    = aole_pkg::ST_OK;
    count_nxt = count_r;
    unique case (in_ch.cmd)
      aole_pkg::CMD_INSERT: begin
        if (count_r == CNT_W'(CAPACITY)) begin
          status = aole_pkg::ST_FULL;
        end else if (pos_x > cnt_x) begin
          status = aole_pkg::ST_RANGE;
        end else begin
          ctrl.ins  = 1'b1;
          count_nxt = count_r + CNT_W'(1);
        end
      end
      aole_pkg::CMD_DELETE: begin
        if (pos_x >= cnt_x) begin
          status = aole_pkg::ST_RANGE;
        end else begin
          ctrl.del  = 1'b1;
          count_nxt = count_r - CNT_W'(1);
        end
      end
      aole_pkg::CMD_READ: begin
        if (pos_x >= cnt_x) begin
          status = aole_pkg::ST_RANGE;
        end else begin
          ctrl.rd = 1'b1;
        end
      end
      aole_pkg::CMD_OVERWRITE: begin
        if (pos_x >= cnt_x) begin
          status = aole_pkg::ST_RANGE;
        end else begin
          ctrl.ovw = 1'b1;
        end
      end
      aole_pkg::CMD_SEARCH: begin
        ctrl.srch = 1'b1;
      end
      aole_pkg::CMD_CLEAR: begin
        count_nxt = '0;
      end
      default: begin
      end
    endcase
  end

  // Cells only change state on an accepted transaction
  assign cell_ctrl = accept ? ctrl : '0;

  // Row of cells; the end cells feed themselves where no neighbor exists
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    if (i == 0) begin : g_first
      assign cell_left[i] = cell_data[i];
    end else begin : g_mid_l
      assign cell_left[i] = cell_data[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign cell_right[i] = cell_data[i];
    end else begin : g_mid_r
      assign cell_right[i] = cell_data[i+1];
    end

    aole_cell #(
      .DATA_WIDTH (DATA_WIDTH),
      .CNT_W      (CNT_W),
      .INDEX      (i)
    ) u_cell (
      .clk       (clk),
      .ctrl_i    (cell_ctrl),
      .pos_i     (in_ch.position),
      .count_i   (count_r),
      .word_i    (word),
      .left_i    (cell_left[i]),
      .right_i   (cell_right[i]),
      .data_o    (cell_data[i]),
      .match_o   (cell_match[i]),
      .rd_data_o (cell_rd[i])
    );
  end

  // Read bus: at most one cell drives a nonzero word
  always_comb begin
    rd_any = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      rd_any = rd_any | cell_rd[i];
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      count_r     <= '0;
    end else begin
      if (accept) begin
        out_valid_r <= 1'b1;
        count_r     <= count_nxt;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (accept) begin
      rd_val_r    <= aole_pkg::VAL_W'($signed(rd_any));
      found_r     <= |cell_match;
      count_out_r <= aole_pkg::CNT_W'(count_nxt);
      status_r    <= status;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.read_value = rd_val_r;
  assign out_ch.found      = found_r;
  assign out_ch.count      = count_out_r;
  assign out_ch.status     = status_r;

endmodule

// ===== dv/aole_list_checker.sv =====
// Result checker for the ordered array list engine: predicts each command's result and compares.
module aole_list_checker (
  input  logic clk,
  input  logic rst_n,
  aole_in_if   in_mon,
  aole_out_if  out_mon,
  output int   fail_count,
  output int   pending_count,
  output int   list_len_now,
  output int   checked_count,
  output int   full_seen,
  output int   range_seen,
  output int   hits_seen
);
  timeunit 1ns;
  timeprecision 1ps;
  import aole_pkg::*;

  localparam int LIST_CAP = 64;

  typedef struct packed {
    logic signed [VAL_W-1:0] read_value;
    logic                    found;
    logic [CNT_W-1:0]        count;
    logic [STAT_W-1:0]       status;
  } list_result_t;

  // Predicted contents of the list
  logic signed [VAL_W-1:0] list_words [LIST_CAP];
  int                      list_len;

  // Expected results, oldest first
  list_result_t            pending_results [$];
  list_result_t            want;
  list_result_t            got;

  // Apply one command to the predicted list and return its result
  function automatic list_result_t apply_command(input logic [2:0] op,
                                                 input logic [POS_W-1:0] pos,
                                                 input logic signed [VAL_W-1:0] word);
    list_result_t res;
    int           p;
    res = '0;
    res.status = ST_OK;
    p = int'(pos);
    case (op)
      CMD_INSERT: begin
        if (list_len >= LIST_CAP) begin
          res.status = ST_FULL;
        end else if (p > list_len) begin
          res.status = ST_RANGE;
        end else begin
          for (int k = list_len; k > p; k--) list_words[k] = list_words[k-1];
          list_words[p] = word;
          list_len++;
        end
      end
      CMD_DELETE: begin
        if (p >= list_len) begin
          res.status = ST_RANGE;
        end else begin
          for (int k = p; k + 1 < list_len; k++) list_words[k] = list_words[k+1];
          list_len--;
        end
      end
      CMD_READ: begin
        if (p >= list_len) res.status = ST_RANGE;
        else res.read_value = list_words[p];
      end
      CMD_OVERWRITE: begin
        if (p >= list_len) res.status = ST_RANGE;
        else list_words[p] = word;
      end
      CMD_SEARCH: begin
        for (int k = 0; k < list_len; k++) begin
          if (list_words[k] == word) res.found = 1'b1;
        end
      end
      CMD_CLEAR: list_len = 0;
      default: ;  // unused codes do nothing
    endcase
    res.count = list_len[CNT_W-1:0];
    return res;
  endfunction

  initial begin
    fail_count    = 0;
    pending_count = 0;
    list_len      = 0;
    list_len_now  = 0;
    checked_count = 0;
    full_seen     = 0;
    range_seen    = 0;
    hits_seen     = 0;
    foreach (list_words[i]) list_words[i] = '0;
  end

  // Compare completed results first, then queue the prediction for a newly accepted command
  always @(posedge clk) begin
    if (!rst_n) begin
      list_len = 0;
      pending_results.delete();
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        got.read_value = out_mon.read_value;
        got.found      = out_mon.found;
        got.count      = out_mon.count;
        got.status     = out_mon.status;
        if (pending_results.size() == 0) begin
          fail_count++;
          $display("%0t ERROR unexpected result: rd=%0d found=%0b count=%0d status=%0d",
                   $realtime, got.read_value, got.found, got.count, got.status);
        end else begin
          want = pending_results.pop_front();
          checked_count++;
          if (want.status == ST_FULL) full_seen++;
          if (want.status == ST_RANGE) range_seen++;
          if (want.found) hits_seen++;
          if (got !== want) begin
            fail_count++;
            $display("%0t ERROR result mismatch: expected rd=%0d found=%0b count=%0d status=%0d",
                     $realtime, want.read_value, want.found, want.count, want.status);
            $display("%0t        actual            rd=%0d found=%0b count=%0d status=%0d",
                     $realtime, got.read_value, got.found, got.count, got.status);
          end
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        pending_results.push_back(apply_command(in_mon.cmd, in_mon.position, in_mon.value));
      end
    end
    pending_count = pending_results.size();
    list_len_now  = list_len;
  end

endmodule

// ===== dv/tb_ordered_array_list_engine.sv =====
// Testbench top for the ordered array list engine: clock, reset, command stimulus and verdict.
module tb_ordered_array_list_engine;
  timeunit 1ns;
  timeprecision 1ps;
  import aole_pkg::*;

  localparam int LIST_CAP   = 64;
  localparam int ITEM_GOAL  = 550;
  localparam int IDLE_LIMIT = 3000;
  localparam logic [2:0] CMD_SPARE6 = 3'd6;
  localparam logic [2:0] CMD_SPARE7 = 3'd7;
  localparam logic signed [VAL_W-1:0] WORD_MIN = 32'sh8000_0000;
  localparam logic signed [VAL_W-1:0] WORD_MAX = 32'sh7FFF_FFFF;

  logic clk;
  logic rst_n;

  aole_in_if  in_ch();
  aole_out_if out_ch();

  int fail_count, pending_count, list_len_now;
  int checked_count, full_seen, range_seen, hits_seen;
  int sent_total;
  int idle_cycles;
  bit tx_burst;
  bit rx_hold_req;

  ordered_array_list_engine DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  aole_list_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_mon        (in_ch),
    .out_mon       (out_ch),
    .fail_count    (fail_count),
    .pending_count (pending_count),
    .list_len_now  (list_len_now),
    .checked_count (checked_count),
    .full_seen     (full_seen),
    .range_seen    (range_seen),
    .hits_seen     (hits_seen)
  );

  // Clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog: cycles with no transaction on either channel
  always @(posedge clk) begin
    if (!rst_n) begin
      idle_cycles <= 0;
    end else if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t watchdog: no transaction for %0d cycles", $realtime, IDLE_LIMIT);
      $display("FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Result side: random stalls, stall-free stretches, and one long hold-off on request
  initial begin
    int r;
    int n;
    out_ch.ready <= 1'b0;
    @(posedge rst_n);
    @(negedge clk);
    forever begin
      r = $urandom_range(0, 99);
      if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        out_ch.ready <= 1'b0;
        n = 120;
      end else if (r < 5) begin
        out_ch.ready <= 1'b1;
        n = 50;
      end else if (r < 70) begin
        out_ch.ready <= 1'b1;
        n = $urandom_range(1, 8);
      end else if (r < 95) begin
        out_ch.ready <= 1'b0;
        n = $urandom_range(1, 3);
      end else begin
        out_ch.ready <= 1'b0;
        n = $urandom_range(10, 40);
      end
      repeat (n) @(negedge clk);
    end
  end

  // Gap between commands, skipped during bursts
  task automatic pause_tx();
    int r;
    int n;
    r = $urandom_range(0, 99);
    if (tx_burst || r < 65) n = 0;
    else if (r < 95) n = $urandom_range(1, 3);
    else n = $urandom_range(10, 40);
    if (n > 0) begin
      in_ch.valid <= 1'b0;
      repeat (n) @(negedge clk);
    end
  endtask

  // Offer one command at the falling edge and hold it until accepted
  task automatic send_cmd(input logic [2:0] op, input logic [POS_W-1:0] pos,
                          input logic signed [VAL_W-1:0] word);
    in_ch.valid    <= 1'b1;
    in_ch.cmd      <= op;
    in_ch.position <= pos;
    in_ch.value    <= word;
    do @(posedge clk); while (!in_ch.ready);
    sent_total++;
    @(negedge clk);
    pause_tx();
  endtask

  // Data word: small pool so searches hit, extremes, or fully random
  function automatic logic signed [VAL_W-1:0] pick_word();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return VAL_W'($urandom_range(0, 7));
    if (r < 45) return WORD_MIN;
    if (r < 50) return WORD_MAX;
    if (r < 55) return -1;
    return $urandom;
  endfunction

  // Position: mostly within 0..top, sometimes anywhere in the field
  function automatic logic [POS_W-1:0] pick_pos(input int top);
    if ($urandom_range(0, 99) < 15 || top < 0) return POS_W'($urandom_range(0, 127));
    return POS_W'($urandom_range(0, top));
  endfunction

  // One weighted random command against the current list
  task automatic send_mixed();
    int r;
    r = $urandom_range(0, 99);
    if (r < 30) send_cmd(CMD_INSERT, pick_pos(list_len_now), pick_word());
    else if (r < 50) send_cmd(CMD_DELETE, pick_pos(list_len_now - 1), pick_word());
    else if (r < 70) send_cmd(CMD_READ, pick_pos(list_len_now - 1), pick_word());
    else if (r < 82) send_cmd(CMD_OVERWRITE, pick_pos(list_len_now - 1), pick_word());
    else if (r < 95) send_cmd(CMD_SEARCH, pick_pos(127), pick_word());
    else if (r < 98) send_cmd(CMD_CLEAR, pick_pos(127), pick_word());
    else send_cmd(($urandom_range(0, 1) != 0) ? CMD_SPARE7 : CMD_SPARE6,
                  pick_pos(127), pick_word());
  endtask

  // Grow the list to capacity, push on it while full, then probe it
  task automatic fill_list();
    while (list_len_now < LIST_CAP) begin
      send_cmd(CMD_INSERT, POS_W'($urandom_range(0, list_len_now)), pick_word());
    end
    repeat (3) send_cmd(CMD_INSERT, pick_pos(127), pick_word());
    repeat (6) begin
      send_cmd(CMD_SEARCH, '0, pick_word());
      send_cmd(CMD_READ, pick_pos(LIST_CAP - 1), pick_word());
    end
    send_cmd(CMD_OVERWRITE, POS_W'(LIST_CAP - 1), pick_word());
    send_cmd(CMD_READ, POS_W'(LIST_CAP - 1), pick_word());
    send_cmd(CMD_READ, POS_W'(LIST_CAP), pick_word());
  endtask

  // Shrink the list to empty by deletes, with the odd miss
  task automatic drain_list();
    while (list_len_now > 0) begin
      send_cmd(CMD_DELETE, pick_pos(list_len_now - 1), pick_word());
    end
    send_cmd(CMD_DELETE, '0, pick_word());
  endtask

  // Stimulus and verdict
  initial begin
    int phase;
    rst_n          <= 1'b0;
    in_ch.valid    <= 1'b0;
    in_ch.cmd      <= CMD_INSERT;
    in_ch.position <= '0;
    in_ch.value    <= '0;
    tx_burst       = 1'b0;
    rx_hold_req    = 1'b0;
    sent_total     = 0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: empty list, ends, middle, extremes, spare codes, clear
    send_cmd(CMD_READ, 7'd0, '0);
    send_cmd(CMD_DELETE, 7'd0, '0);
    send_cmd(CMD_OVERWRITE, 7'd0, 32'sd5);
    send_cmd(CMD_SEARCH, 7'd0, '0);
    send_cmd(CMD_INSERT, 7'd1, 32'sd9);
    send_cmd(CMD_INSERT, 7'd0, WORD_MIN);
    send_cmd(CMD_INSERT, 7'd1, WORD_MAX);
    send_cmd(CMD_INSERT, 7'd0, -1);
    send_cmd(CMD_INSERT, 7'd1, '0);
    send_cmd(CMD_READ, 7'd0, '0);
    send_cmd(CMD_READ, 7'd3, '0);
    send_cmd(CMD_READ, 7'd4, '0);
    send_cmd(CMD_SEARCH, 7'd0, WORD_MAX);
    send_cmd(CMD_SEARCH, 7'd0, 32'sd12345);
    send_cmd(CMD_OVERWRITE, 7'd3, 32'sh5A5A_5A5A);
    send_cmd(CMD_DELETE, 7'd1, '0);
    send_cmd(CMD_DELETE, 7'd2, '0);
    send_cmd(CMD_SPARE6, 7'd0, '0);
    send_cmd(CMD_SPARE7, 7'd127, -1);
    send_cmd(CMD_READ, 7'd127, '0);
    send_cmd(CMD_CLEAR, 7'd0, '0);
    send_cmd(CMD_READ, 7'd0, '0);
    send_cmd(CMD_INSERT, 7'd64, WORD_MAX);
    send_cmd(CMD_SEARCH, 7'd0, WORD_MIN);

    // Back-pressure: receiver holds off while commands keep coming
    rx_hold_req = 1'b1;
    tx_burst    = 1'b1;
    repeat (25) send_mixed();
    tx_burst = 1'b0;

    // Random phases, the first one filling the list
    fill_list();
    while (sent_total < ITEM_GOAL) begin
      tx_burst = ($urandom_range(0, 4) == 0);
      phase = $urandom_range(0, 9);
      if (phase < 2) fill_list();
      else if (phase == 2) drain_list();
      else repeat (20) send_mixed();
    end
    tx_burst = 1'b0;
    in_ch.valid <= 1'b0;

    // Drain outstanding results, then let the pipeline settle
    wait (pending_count == 0);
    repeat (4) @(posedge clk);

    $display("Ran %0d commands with %0d results checked across empty, partial and full lists.",
             sent_total, checked_count);
    $display("Full-list inserts %0d, out-of-range positions %0d, search hits %0d.",
             full_seen, range_seen, hits_seen);
    if (fail_count == 0 && pending_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
